// ===== hdl/car_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the comb/allpass reverberator.
// Used by car_mac and comb_allpass_reverb; no dependencies of its own.
package car_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int RND_W    = PROD_W - FRAC_W;
  localparam int SAT_W    = 48;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  localparam int COEF_BASE = 1116;
  localparam int COEF_STEP = 100;

  localparam int DELAY_DEPTH_DEF   = 2048;
  localparam int COMB_COUNT_DEF    = 8;
  localparam int ALLPASS_COUNT_DEF = 4;

  localparam logic [GAIN_W-1:0] ROOM_SIZE_RST     = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] FEEDBACK_GAIN_RST = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0] WET_LEVEL_RST     = GAIN_W'(21627);
  localparam logic [GAIN_W-1:0] DRY_LEVEL_RST     = GAIN_W'(26214);

  typedef enum logic [1:0] {
    REG_ROOM_SIZE,
    REG_FEEDBACK_GAIN,
    REG_WET_LEVEL,
    REG_DRY_LEVEL
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_DLY,
    ST_C_ADDR,
    ST_C_MUL,
    ST_C_WR,
    ST_A_DLY,
    ST_A_ADDR,
    ST_A_MUL,
    ST_A_Y,
    ST_A_FB,
    ST_A_WR,
    ST_M_DRY,
    ST_M_WET,
    ST_M_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       block_end;
  } audio_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
  } mix_t;

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(8388607);
    lo = -SAT_W'(8388608);
    if (v > hi) begin
      return SAMPLE_W'(hi);
    end else if (v < lo) begin
      return SAMPLE_W'(lo);
    end
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > UNITY) ? UNITY : g;
  endfunction

endpackage

// ===== hdl/car_mac.sv =====
`timescale 1ns / 1ps
// Shared sample-by-gain multiplier (Q1.16 gain) with a registered product and rounding.
// Depends on car_pkg for widths.
module car_mac (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [car_pkg::SAMPLE_W-1:0] a,
  input  logic        [car_pkg::GAIN_W-1:0]   b,
  output logic signed [car_pkg::PROD_W-1:0]   prod,
  output logic signed [car_pkg::RND_W-1:0]    rnd
);

  logic signed [car_pkg::PROD_W-1:0] biased;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= car_pkg::PROD_W'(a * $signed({1'b0, b}));
    end
  end

  // round to nearest, ties up: add half then take the floor
  assign biased = prod + $signed(car_pkg::ROUND_HALF);
  assign rnd    = biased[car_pkg::PROD_W-1:car_pkg::FRAC_W];

endmodule

// ===== hdl/car_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
module car_ram #(
  parameter  int WIDTH  = 24,
  parameter  int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/comb_allpass_reverb.sv =====
`timescale 1ns / 1ps
// Mono reverberator: parallel feedback combs into a chain of allpass stages.
// Uses car_pkg, car_mac (shared multiplier) and car_ram (delay rings).
//
// Input channel audio_valid/audio_stall/audio carries one sample per transfer;
// output channel mix_valid/mix_stall/mix returns one mixed sample per input,
// in order, with block_end copied through. Registers are written on the
// cfg_we/cfg_index/cfg_data port; the user must do so only while the block is
// idle, as the block itself does not enforce it. Each sample runs per comb a
// delay, address, multiply and write step, per allpass a delay, address,
// multiply, y, feedback and write step, then dry, wet and output mix steps;
// a new sample is taken only once the block is back in idle. The steps share
// the single multiplier: each comb uses it for its delay and its feedback
// product, each allpass for its delay and two products, with one ring read
// per stage. audio_stall is high whenever a sample is in progress.
// Reset clears the registers to their defaults, the ring position and a fill
// count; ring entries not yet written read as zero through that count, so no
// clearing pass is run and the block takes samples right after reset.
// If the receiver stalls, the finished sample holds in the output register
// and the block waits before its final step until the register is free.
module comb_allpass_reverb #(
  parameter int DELAY_DEPTH   = car_pkg::DELAY_DEPTH_DEF,
  parameter int COMB_COUNT    = car_pkg::COMB_COUNT_DEF,
  parameter int ALLPASS_COUNT = car_pkg::ALLPASS_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        audio_valid,
  output logic                        audio_stall,
  input  car_pkg::audio_t             audio,
  output logic                        mix_valid,
  input  logic                        mix_stall,
  output car_pkg::mix_t               mix,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [car_pkg::GAIN_W-1:0]  cfg_data
);

  localparam int MAXC     = (COMB_COUNT > ALLPASS_COUNT) ? COMB_COUNT : ALLPASS_COUNT;
  localparam int PTR_W    = $clog2(DELAY_DEPTH);
  localparam int DLY_W    = $clog2(DELAY_DEPTH + 1);
  localparam int IDX_W    = $clog2(MAXC + 1);
  localparam int COEF_MAX = car_pkg::COEF_BASE + car_pkg::COEF_STEP * (MAXC - 1);
  localparam int COEF_W   = $clog2(COEF_MAX + 1);
  localparam int CMP_W    = (COEF_W > DLY_W) ? COEF_W : DLY_W;
  localparam int BASE_W   = $clog2(MAXC * DELAY_DEPTH);
  localparam int CA_W     = $clog2(COMB_COUNT * DELAY_DEPTH);
  localparam int AA_W     = $clog2(ALLPASS_COUNT * DELAY_DEPTH);
  localparam int CSUM_W   = car_pkg::SAMPLE_W + $clog2(COMB_COUNT);
  localparam int SW       = car_pkg::SAMPLE_W;
  localparam int GW       = car_pkg::GAIN_W;
  localparam int XW       = car_pkg::SAT_W;

  car_pkg::state_t state, state_next;

  logic [GW-1:0] room_size, feedback_gain, wet_level, dry_level;
  logic [GW-1:0] room_c, gain_c, wet_c, dry_c, coef_c;

  logic [PTR_W-1:0] ptr;
  logic [DLY_W-1:0] fill;

  logic signed [SW-1:0]     x;
  logic                     blk;
  logic signed [CSUM_W-1:0] csum;
  logic signed [SW-1:0]     wet;
  logic signed [SW-1:0]     bval;
  logic signed [SW-1:0]     y;
  logic signed [car_pkg::RND_W-1:0] dry_part;
  logic [IDX_W-1:0]         idx;
  logic [COEF_W-1:0]        coef;
  logic [BASE_W-1:0]        base;
  logic                     hit;

  logic                             mac_en;
  logic signed [SW-1:0]             mac_a;
  logic [GW-1:0]                    mac_b;
  logic signed [car_pkg::PROD_W-1:0] mac_prod;
  logic signed [car_pkg::RND_W-1:0]  mac_rnd;

  logic [COEF_W-1:0] raw_dly;
  logic [CMP_W-1:0]  raw_ext;
  logic [DLY_W-1:0]  dly_full, halved, dly_use, ptr_ext;
  logic [PTR_W-1:0]  rpos;
  logic [BASE_W-1:0] raddr, waddr;

  logic [SW-1:0]        comb_rdata, ap_rdata;
  logic signed [SW-1:0] v_comb;
  logic signed [SW-1:0] comb_wdata, ap_wdata, y_next, mix_next;
  logic                 comb_we, ap_we;
  logic                 comb_last, ap_last, out_free;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      room_size     <= car_pkg::ROOM_SIZE_RST;
      feedback_gain <= car_pkg::FEEDBACK_GAIN_RST;
      wet_level     <= car_pkg::WET_LEVEL_RST;
      dry_level     <= car_pkg::DRY_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (car_pkg::reg_index_t'(cfg_index))
        car_pkg::REG_ROOM_SIZE:     room_size     <= cfg_data;
        car_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data;
        car_pkg::REG_WET_LEVEL:     wet_level     <= cfg_data;
        car_pkg::REG_DRY_LEVEL:     dry_level     <= cfg_data;
      endcase
    end
  end

  assign room_c = car_pkg::clamp_gain(room_size);
  assign gain_c = car_pkg::clamp_gain(feedback_gain);
  assign wet_c  = car_pkg::clamp_gain(wet_level);
  assign dry_c  = car_pkg::clamp_gain(dry_level);
  assign coef_c = room_c >> 1;

  // ----------------------------------------------------------- delay address
  assign raw_dly = mac_prod[car_pkg::FRAC_W +: COEF_W];

  always_comb begin
    raw_ext = CMP_W'(raw_dly);
    if (raw_ext == '0) begin
      dly_full = DLY_W'(1);
    end else if (raw_ext > CMP_W'(DELAY_DEPTH)) begin
      dly_full = DLY_W'(DELAY_DEPTH);
    end else begin
      dly_full = DLY_W'(raw_ext);
    end
    halved = dly_full >> 1;
    if (state == car_pkg::ST_A_ADDR) begin
      dly_use = (halved == '0) ? DLY_W'(1) : halved;
    end else begin
      dly_use = dly_full;
    end
    ptr_ext = DLY_W'(ptr);
    // wrap the read position back into the ring
    if (ptr_ext >= dly_use) begin
      rpos = PTR_W'(ptr_ext - dly_use);
    end else begin
      rpos = PTR_W'(ptr_ext + (DLY_W'(DELAY_DEPTH) - dly_use));
    end
    raddr = base + BASE_W'(rpos);
    waddr = base + BASE_W'(ptr);
  end

  // ----------------------------------------------------------------- datapath
  assign v_comb     = hit ? $signed(comb_rdata) : '0;
  assign comb_wdata = car_pkg::sat24(XW'(x) + XW'(mac_rnd));
  assign ap_wdata   = car_pkg::sat24(XW'(wet) + XW'(mac_rnd));
  assign y_next     = car_pkg::sat24(XW'(bval) - XW'(mac_rnd));
  assign mix_next   = car_pkg::sat24(XW'(dry_part) + XW'(mac_rnd));
  assign comb_last  = (idx == IDX_W'(COMB_COUNT - 1));
  assign ap_last    = (idx == IDX_W'(ALLPASS_COUNT - 1));
  assign out_free   = !mix_valid || !mix_stall;
  assign audio_stall = (state != car_pkg::ST_IDLE);

  car_mac u_mac (
    .clk  (clk),
    .en   (mac_en),
    .a    (mac_a),
    .b    (mac_b),
    .prod (mac_prod),
    .rnd  (mac_rnd)
  );

  car_ram #(.WIDTH(SW), .DEPTH(COMB_COUNT * DELAY_DEPTH)) u_comb_ring (
    .clk   (clk),
    .we    (comb_we),
    .waddr (CA_W'(waddr)),
    .wdata (comb_wdata),
    .raddr (CA_W'(raddr)),
    .rdata (comb_rdata)
  );

  car_ram #(.WIDTH(SW), .DEPTH(ALLPASS_COUNT * DELAY_DEPTH)) u_ap_ring (
    .clk   (clk),
    .we    (ap_we),
    .waddr (AA_W'(waddr)),
    .wdata (ap_wdata),
    .raddr (AA_W'(raddr)),
    .rdata (ap_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= car_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac_en     = 1'b0;
    mac_a      = x;
    mac_b      = room_c;
    comb_we    = 1'b0;
    ap_we      = 1'b0;
    unique case (state)
      car_pkg::ST_IDLE: begin
        if (audio_valid) begin
          state_next = car_pkg::ST_C_DLY;
        end
      end
      car_pkg::ST_C_DLY: begin
        mac_en     = 1'b1;
        mac_a      = $signed(SW'(coef));
        state_next = car_pkg::ST_C_ADDR;
      end
      car_pkg::ST_C_ADDR: state_next = car_pkg::ST_C_MUL;
      car_pkg::ST_C_MUL: begin
        mac_en     = 1'b1;
        mac_a      = v_comb;
        mac_b      = gain_c;
        state_next = car_pkg::ST_C_WR;
      end
      car_pkg::ST_C_WR: begin
        comb_we    = 1'b1;
        state_next = comb_last ? car_pkg::ST_A_DLY : car_pkg::ST_C_DLY;
      end
      car_pkg::ST_A_DLY: begin
        mac_en     = 1'b1;
        mac_a      = $signed(SW'(coef));
        state_next = car_pkg::ST_A_ADDR;
      end
      car_pkg::ST_A_ADDR: state_next = car_pkg::ST_A_MUL;
      car_pkg::ST_A_MUL: begin
        mac_en     = 1'b1;
        mac_a      = wet;
        mac_b      = coef_c;
        state_next = car_pkg::ST_A_Y;
      end
      car_pkg::ST_A_Y: state_next = car_pkg::ST_A_FB;
      car_pkg::ST_A_FB: begin
        mac_en     = 1'b1;
        mac_a      = y;
        mac_b      = coef_c;
        state_next = car_pkg::ST_A_WR;
      end
      car_pkg::ST_A_WR: begin
        ap_we      = 1'b1;
        state_next = ap_last ? car_pkg::ST_M_DRY : car_pkg::ST_A_DLY;
      end
      car_pkg::ST_M_DRY: begin
        mac_en     = 1'b1;
        mac_b      = dry_c;
        state_next = car_pkg::ST_M_WET;
      end
      car_pkg::ST_M_WET: begin
        mac_en     = 1'b1;
        mac_a      = wet;
        mac_b      = wet_c;
        state_next = car_pkg::ST_M_OUT;
      end
      car_pkg::ST_M_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          state_next = car_pkg::ST_IDLE;
        end
      end
      default: state_next = car_pkg::ST_IDLE;
    endcase
  end

  // working values, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      car_pkg::ST_IDLE: begin
        if (audio_valid) begin
          x    <= audio.sample_in;
          blk  <= audio.block_end;
          csum <= '0;
          idx  <= '0;
          coef <= COEF_W'(car_pkg::COEF_BASE);
          base <= '0;
        end
      end
      car_pkg::ST_C_ADDR, car_pkg::ST_A_ADDR: begin
        hit <= (fill >= dly_use);
      end
      car_pkg::ST_C_MUL: begin
        csum <= csum + CSUM_W'(v_comb);
      end
      car_pkg::ST_C_WR: begin
        if (comb_last) begin
          wet  <= car_pkg::sat24(XW'(csum));
          idx  <= '0;
          coef <= COEF_W'(car_pkg::COEF_BASE);
          base <= '0;
        end else begin
          idx  <= idx + IDX_W'(1);
          coef <= coef + COEF_W'(car_pkg::COEF_STEP);
          base <= base + BASE_W'(DELAY_DEPTH);
        end
      end
      car_pkg::ST_A_MUL: begin
        bval <= hit ? $signed(ap_rdata) : '0;
      end
      car_pkg::ST_A_Y: begin
        y <= y_next;
      end
      car_pkg::ST_A_WR: begin
        wet  <= y;
        idx  <= idx + IDX_W'(1);
        coef <= coef + COEF_W'(car_pkg::COEF_STEP);
        base <= base + BASE_W'(DELAY_DEPTH);
      end
      car_pkg::ST_M_WET: begin
        dry_part <= mac_rnd;
      end
      car_pkg::ST_M_OUT: begin
        if (out_free) begin
          mix.sample_out    <= mix_next;
          mix.block_end_out <= blk;
        end
      end
      default: begin
      end
    endcase
  end

  // ring position, fill count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      fill      <= '0;
      mix_valid <= 1'b0;
    end else if (state == car_pkg::ST_M_OUT && out_free) begin
      mix_valid <= 1'b1;
      ptr       <= (ptr == PTR_W'(DELAY_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
      if (fill != DLY_W'(DELAY_DEPTH)) begin
        fill <= fill + DLY_W'(1);
      end
    end else if (mix_valid && !mix_stall) begin
      mix_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == car_pkg::ST_IDLE && audio_valid) |=> (state == car_pkg::ST_C_DLY))
    else $error("sample transfer did not start the comb pass");

  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    (state != car_pkg::ST_M_OUT) |=> $stable(ptr))
    else $error("ring position moved outside the output step");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    DLY_W'(ptr) < DLY_W'(DELAY_DEPTH))
    else $error("ring position out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= DLY_W'(DELAY_DEPTH))
    else $error("fill count beyond ring depth");

  a_dly_range: assert property (@(posedge clk) disable iff (rst)
    (state == car_pkg::ST_C_ADDR || state == car_pkg::ST_A_ADDR) |->
      (dly_use != '0 && dly_use <= DLY_W'(DELAY_DEPTH)))
    else $error("delay outside one to ring depth");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for comb_allpass_reverb: directed table, then random phases.
// Depends on car_pkg and the reverberator RTL; predicts every mixed sample internally.
module testbench;

  localparam int DEPTH    = car_pkg::DELAY_DEPTH_DEF;
  localparam int COMBS    = car_pkg::COMB_COUNT_DEF;
  localparam int ALLPASS  = car_pkg::ALLPASS_COUNT_DEF;
  localparam int SW       = car_pkg::SAMPLE_W;
  localparam int GW       = car_pkg::GAIN_W;
  localparam int HOLD_OFF = 400;
  localparam int TAIL     = 80;

  typedef struct packed {
    logic [1:0]    grp;
    logic [SW-1:0] smp;
    logic          be;
    logic          known;
    logic [SW-1:0] want;
  } stim_row_t;

  typedef struct packed {
    logic [GW-1:0] room;
    logic [GW-1:0] fb;
    logic [GW-1:0] wet;
    logic [GW-1:0] dry;
  } level_set_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              audio_valid = 1'b0;
  logic              audio_stall;
  car_pkg::audio_t   audio = '0;
  logic              mix_valid;
  logic              mix_stall = 1'b0;
  car_pkg::mix_t     mix;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [GW-1:0]     cfg_data = '0;

  // mirror of the block: registers, delay rings and ring position
  logic [GW-1:0]              room_reg = car_pkg::ROOM_SIZE_RST;
  logic [GW-1:0]              fb_reg   = car_pkg::FEEDBACK_GAIN_RST;
  logic [GW-1:0]              wet_reg  = car_pkg::WET_LEVEL_RST;
  logic [GW-1:0]              dry_reg  = car_pkg::DRY_LEVEL_RST;
  bit signed [SW-1:0]         comb_ring [COMBS][DEPTH];
  bit signed [SW-1:0]         ap_ring [ALLPASS][DEPTH];
  int unsigned                ring_pos = 0;

  car_pkg::mix_t expected_mix [$];
  int unsigned mismatches = 0;
  bit          hold_armed = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned rx_cycle = 0;

  // group 0 rows have a plain dry path (wet off, dry clamped to unity): out = in
  stim_row_t dir_rows [0:21] = '{
    '{2'd0, 24'h000000, 1'b0, 1'b1, 24'h000000},
    '{2'd0, 24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF},
    '{2'd0, 24'h800000, 1'b0, 1'b1, 24'h800000},
    '{2'd0, 24'h000001, 1'b1, 1'b1, 24'h000001},
    '{2'd0, 24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF},
    '{2'd0, 24'h555555, 1'b0, 1'b1, 24'h555555},
    '{2'd0, 24'hAAAAAA, 1'b1, 1'b1, 24'hAAAAAA},
    '{2'd1, 24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'h7FFFFF, 1'b1, 1'b0, 24'h000000},
    '{2'd1, 24'h800000, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'h800000, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'h800000, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'h800000, 1'b1, 1'b0, 24'h000000},
    '{2'd1, 24'h000000, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'h000001, 1'b0, 1'b0, 24'h000000},
    '{2'd1, 24'hFFFFFF, 1'b1, 1'b0, 24'h000000},
    '{2'd2, 24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{2'd2, 24'h800000, 1'b1, 1'b0, 24'h000000},
    '{2'd2, 24'h003039, 1'b0, 1'b0, 24'h000000},
    '{2'd2, 24'hFFCFC7, 1'b1, 1'b0, 24'h000000}
  };

  // wet off / zero room size with feedback gain above one / longest delays with no feedback
  level_set_t dir_settings [0:2] = '{
    '{17'd0,      17'd65536,  17'd0,      17'd131071},
    '{17'd0,      17'd131071, 17'd65536,  17'd0},
    '{17'd131071, 17'd0,      17'd131071, 17'd65536}
  };

  comb_allpass_reverb uut (
    .clk        (clk),
    .rst        (rst),
    .audio_valid(audio_valid),
    .audio_stall(audio_stall),
    .audio      (audio),
    .mix_valid  (mix_valid),
    .mix_stall  (mix_stall),
    .mix        (mix),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) begin
      return 64'sd8388607;
    end else if (v < -64'sd8388608) begin
      return -64'sd8388608;
    end
    return v;
  endfunction

  function automatic longint unsigned level_clip(logic [GW-1:0] g);
    return (g > 17'd65536) ? 65536 : longint'(g);
  endfunction

  // floor((a*g + half) / 2^16): the arithmetic shift rounds toward minus infinity
  function automatic longint q16_scale(longint a, longint unsigned g);
    return (a * longint'(g) + 64'sd32768) >>> 16;
  endfunction

  function automatic int unsigned tap_delay(int unsigned idx, longint unsigned room);
    longint unsigned d;
    d = (longint'(car_pkg::COEF_BASE + car_pkg::COEF_STEP * idx) * room) >> 16;
    if (d < 1) begin
      d = 1;
    end
    if (d > DEPTH) begin
      d = DEPTH;
    end
    return int'(d);
  endfunction

  function automatic car_pkg::mix_t reverb_predict(car_pkg::audio_t a);
    longint x, wet, v, b, y, mixed;
    longint unsigned room, fb, coef;
    int unsigned i, d, e;
    car_pkg::mix_t r;
    x    = longint'($signed(a.sample_in));
    room = level_clip(room_reg);
    fb   = level_clip(fb_reg);
    coef = room >> 1;
    wet  = 0;
    for (i = 0; i < COMBS; i++) begin
      d = tap_delay(i, room);
      v = longint'(comb_ring[i][(ring_pos + DEPTH - d) % DEPTH]);
      wet += v;
      comb_ring[i][ring_pos] = SW'(clip24(x + q16_scale(v, fb)));
    end
    wet = clip24(wet);
    for (i = 0; i < ALLPASS; i++) begin
      e = tap_delay(i, room) / 2;
      if (e < 1) begin
        e = 1;
      end
      b = longint'(ap_ring[i][(ring_pos + DEPTH - e) % DEPTH]);
      y = clip24(b - q16_scale(wet, coef));
      ap_ring[i][ring_pos] = SW'(clip24(wet + q16_scale(y, coef)));
      wet = y;
    end
    mixed = clip24(q16_scale(x, level_clip(dry_reg)) + q16_scale(wet, level_clip(wet_reg)));
    r.sample_out    = mixed[SW-1:0];
    r.block_end_out = a.block_end;
    ring_pos = (ring_pos + 1) % DEPTH;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_mix(car_pkg::mix_t got);
    car_pkg::mix_t want;
    if (expected_mix.size() == 0) begin
      report_mismatch("result with nothing pending, sample_out", $signed(got.sample_out), 0);
    end else begin
      want = expected_mix.pop_front();
      if (got.sample_out !== want.sample_out) begin
        report_mismatch("sample_out", $signed(got.sample_out), $signed(want.sample_out));
      end
      if (got.block_end_out !== want.block_end_out) begin
        report_mismatch("block_end_out", got.block_end_out, want.block_end_out);
      end
    end
  endtask

  // receiver: check each transfer, stall on a shifting pattern, one long hold-off
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (!rst && mix_valid && !mix_stall) begin
      check_mix(mix);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = HOLD_OFF;
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 120);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      mix_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: mix_stall <= 1'b0;
        1: mix_stall <= ($urandom_range(0, 7) == 0);
        2: mix_stall <= 1'($urandom_range(0, 1));
        default: mix_stall <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  task automatic offer_sample(car_pkg::audio_t a, bit known, logic [SW-1:0] want);
    car_pkg::mix_t exp_mix;
    audio <= a;
    audio_valid <= 1'b1;
    @(posedge clk);
    while (audio_stall) begin
      @(posedge clk);
    end
    exp_mix = reverb_predict(a);
    if (known) begin
      exp_mix.sample_out = want;
    end
    expected_mix.push_back(exp_mix);
  endtask

  task automatic wait_drained();
    while (expected_mix.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic load_settings(level_set_t s);
    cfg_we <= 1'b1;
    cfg_index <= car_pkg::REG_ROOM_SIZE;
    cfg_data <= s.room;
    @(posedge clk);
    cfg_index <= car_pkg::REG_FEEDBACK_GAIN;
    cfg_data <= s.fb;
    @(posedge clk);
    cfg_index <= car_pkg::REG_WET_LEVEL;
    cfg_data <= s.wet;
    @(posedge clk);
    cfg_index <= car_pkg::REG_DRY_LEVEL;
    cfg_data <= s.dry;
    @(posedge clk);
    cfg_we <= 1'b0;
    room_reg = s.room;
    fb_reg   = s.fb;
    wet_reg  = s.wet;
    dry_reg  = s.dry;
  endtask

  function automatic logic [GW-1:0] random_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 17'd65536;
      2: return GW'($urandom_range(65537, 131071));
      default: return GW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic car_pkg::audio_t random_sample();
    car_pkg::audio_t a;
    case ($urandom_range(0, 7))
      0: a.sample_in = 24'h7FFFFF;
      1: a.sample_in = 24'h800000;
      2, 3: a.sample_in = SW'(int'($urandom_range(0, 4000)) - 2000);
      default: a.sample_in = SW'($urandom);
    endcase
    a.block_end = ($urandom_range(0, 9) == 0);
    return a;
  endfunction

  initial begin
    level_set_t      s;
    car_pkg::audio_t a;
    int              cur_grp;
    int unsigned     k, ph, burst_left;
    cur_grp = -1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < 22; k++) begin
      if (int'(dir_rows[k].grp) != cur_grp) begin
        audio_valid <= 1'b0;
        wait_drained();
        cur_grp = int'(dir_rows[k].grp);
        load_settings(dir_settings[cur_grp]);
      end
      a.sample_in = dir_rows[k].smp;
      a.block_end = dir_rows[k].be;
      offer_sample(a, dir_rows[k].known, dir_rows[k].want);
    end

    burst_left = $urandom_range(1, 12);
    for (ph = 0; ph < 8; ph++) begin
      // drop valid and let every pending result arrive before touching registers
      audio_valid <= 1'b0;
      wait_drained();
      s.room = (ph % 3 == 2) ? random_level() : GW'($urandom_range(0, 2500));
      s.fb   = random_level();
      s.wet  = random_level();
      s.dry  = random_level();
      load_settings(s);
      if (ph == 3) begin
        hold_armed = 1'b1;
      end
      for (k = 0; k < 60; k++) begin
        offer_sample(random_sample(), 1'b0, '0);
        burst_left--;
        if (burst_left == 0 && ph != 3) begin
          audio_valid <= 1'b0;
          repeat ($urandom_range(1, 150)) @(posedge clk);
          burst_left = $urandom_range(1, 12);
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    audio_valid <= 1'b0;
    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
